// ===== rtl/dead_reckoning_blend_macros.svh =====
// Assertion macros for the dead-reckoning blend checker.
// All properties sample on the rising edge of clk and are off during reset.
`ifndef DEAD_RECKONING_BLEND_MACROS_SVH
`define DEAD_RECKONING_BLEND_MACROS_SVH

// Same-cycle implication.
`define DRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/drblend_pkg.sv =====
`default_nettype none

package drblend_pkg;

    // field and datapath widths
    localparam int unsigned POS_W      = 32;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned IN_DATA_W  = 192;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned OUT_USER_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned ADDR_W     = 4;

    // product: 33-bit signed by 17-bit signed
    localparam int unsigned PROD_W     = 50;

    // shared divider: 48-bit dividend magnitude, 16-bit divisor, 2 bits a cycle
    localparam int unsigned DVD_W       = 48;
    localparam int unsigned DSR_W       = 16;
    localparam int unsigned DIV_BITS    = 2;
    localparam int unsigned DIV_ITER    = DVD_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_ITER);

    localparam logic [DSR_W-1:0] MS_PER_S       = 16'd1000;
    localparam logic [MS_W-1:0]  ELAPSED_MAX_MS = 16'hFFFF;
    localparam logic [MS_W-1:0]  BLEND_RESET_MS = 16'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_ACC,
        S_OUT
    } state_t;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef enum logic {
        PH_PRED,
        PH_BLEND
    } phase_t;

    typedef enum logic {
        AX_X,
        AX_Y
    } axis_t;

    typedef enum logic [1:0] {
        REG_BLEND_WINDOW = 2'd0,
        REG_START_X      = 2'd1,
        REG_START_Y      = 2'd2
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/dead_reckoning_blend.sv =====
`default_nettype none

// Dead-reckoning tracker for one remote object in 2D, positions in Q16.16.
// A store beat (tuser 0) keeps a move report only if its timestamp is newer
// than the one held, and only then snapshots the current position and time.
// A tick beat (tuser 1) predicts report position + velocity * elapsed/1000
// (elapsed clamped to 65535 ms) and, inside the blend window since the
// snapshot, interpolates from snapshot to prediction; results saturate to
// 32 bits. Every input beat gives exactly one output beat. A tick is paced
// by the single shared divider (2 quotient bits a cycle) and the one shared
// multiplier, used once per axis for the prediction and once more per axis
// for the blend.
// s_axis_tready is low while a beat is being worked on; a finished result
// waits in the output register, so the next beat can be taken meanwhile.
// Registers (APB, 32-bit): 0x0 blend_window_ms, 0x4 start_x, 0x8 start_y;
// writing a start register also moves the current position there.
module dead_reckoning_blend
    import drblend_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_ms, report_time_ms, report_pos_x, report_pos_y,
    // report_vel_x, report_vel_y
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cur_x, cur_y
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // accepted, blending
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    // saturate a wide signed sum to Q16.16
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if ((&v[PROD_W-1:POS_W-1]) || !(|v[PROD_W-1:POS_W-1]))
            r = v[POS_W-1:0];
        else if (v[PROD_W-1])
            r = {1'b1, {(POS_W-1){1'b0}}};
        else
            r = {1'b0, {(POS_W-1){1'b1}}};
        return r;
    endfunction

    // ---- state ----
    state_t state_reg, state_next;
    phase_t phase_reg;
    axis_t  axis_reg;

    // configuration
    logic [MS_W-1:0]         blend_win_reg;
    logic signed [POS_W-1:0] start_x_reg;
    logic signed [POS_W-1:0] start_y_reg;

    // tracker state
    logic [TIME_W-1:0]       newest_time_reg;
    logic signed [POS_W-1:0] newest_pos_x_reg;
    logic signed [POS_W-1:0] newest_pos_y_reg;
    logic signed [POS_W-1:0] newest_vel_x_reg;
    logic signed [POS_W-1:0] newest_vel_y_reg;
    logic signed [POS_W-1:0] snap_x_reg;
    logic signed [POS_W-1:0] snap_y_reg;
    logic [TIME_W-1:0]       snap_time_reg;
    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;

    // per-beat working registers
    logic [MS_W-1:0]          elapsed_reg;
    logic [MS_W-1:0]          since_reg;
    logic                     blend_on_reg;
    logic                     acc_flag_reg;
    logic                     blend_flag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [POS_W-1:0]  pred_reg;

    // output register
    logic                     m_valid_reg;
    logic [OUT_DATA_W-1:0]    m_data_reg;
    logic [OUT_USER_W-1:0]    m_user_reg;

    // ---- input beat fields ----
    logic [TIME_W-1:0]       in_now;
    logic [TIME_W-1:0]       in_rtime;
    logic signed [POS_W-1:0] in_pos_x;
    logic signed [POS_W-1:0] in_pos_y;
    logic signed [POS_W-1:0] in_vel_x;
    logic signed [POS_W-1:0] in_vel_y;
    cmd_t                    in_cmd;

    assign in_now   = s_axis_tdata[31:0];
    assign in_rtime = s_axis_tdata[63:32];
    assign in_pos_x = s_axis_tdata[95:64];
    assign in_pos_y = s_axis_tdata[127:96];
    assign in_vel_x = s_axis_tdata[159:128];
    assign in_vel_y = s_axis_tdata[191:160];
    assign in_cmd   = cmd_t'(s_axis_tuser);

    logic accept_in;
    logic report_newer;
    logic [TIME_W-1:0] elapsed_full;
    logic [TIME_W-1:0] since_full;
    logic [MS_W-1:0]   elapsed_clamped;
    logic              blend_on;

    assign accept_in       = s_axis_tvalid && s_axis_tready;
    assign report_newer    = in_rtime > newest_time_reg;
    // differences wrap like the unsigned counters they come from
    assign elapsed_full    = in_now - newest_time_reg;
    assign since_full      = in_now - snap_time_reg;
    assign elapsed_clamped = (|elapsed_full[TIME_W-1:MS_W]) ? ELAPSED_MAX_MS
                                                            : elapsed_full[MS_W-1:0];
    assign blend_on        = since_full < {{(TIME_W-MS_W){1'b0}}, blend_win_reg};

    // ---- configuration port ----
    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_BLEND_WINDOW: prdata = {{(APB_DATA_W-MS_W){1'b0}}, blend_win_reg};
            REG_START_X:      prdata = start_x_reg;
            REG_START_Y:      prdata = start_y_reg;
            default:          prdata = '0;
        endcase
    end

    // ---- shared multiplier ----
    logic signed [POS_W-1:0]  sel_vel;
    logic signed [POS_W-1:0]  sel_pos;
    logic signed [POS_W-1:0]  sel_snap;
    logic signed [POS_W:0]    mul_a;
    logic signed [MS_W:0]     mul_b;
    logic signed [PROD_W-1:0] prod_full;

    assign sel_vel  = (axis_reg == AX_X) ? newest_vel_x_reg : newest_vel_y_reg;
    assign sel_pos  = (axis_reg == AX_X) ? newest_pos_x_reg : newest_pos_y_reg;
    assign sel_snap = (axis_reg == AX_X) ? snap_x_reg : snap_y_reg;

    // prediction: velocity * elapsed; blend: (prediction - snapshot) * since
    always_comb
    begin
        if (phase_reg == PH_PRED)
        begin
            mul_a = $signed({sel_vel[POS_W-1], sel_vel});
            mul_b = $signed({1'b0, elapsed_reg});
        end
        else
        begin
            mul_a = $signed({pred_reg[POS_W-1], pred_reg})
                  - $signed({sel_snap[POS_W-1], sel_snap});
            mul_b = $signed({1'b0, since_reg});
        end
    end

    assign prod_full = mul_a * mul_b;

    // ---- shared divider: round half away from zero on the magnitude ----
    logic [DSR_W-1:0]  div_divisor;
    logic [PROD_W-1:0] prod_mag;
    logic [DVD_W-1:0]  div_dividend;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;

    assign div_divisor  = (phase_reg == PH_PRED) ? MS_PER_S : blend_win_reg;
    assign prod_mag     = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign div_dividend = prod_mag[DVD_W-1:0] + DVD_W'(div_divisor >> 1);

    drblend_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---- accumulate: base + signed quotient, saturated ----
    logic signed [PROD_W-1:0] q_ext;
    logic signed [PROD_W-1:0] q_signed;
    logic signed [POS_W-1:0]  acc_base;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [POS_W-1:0]  acc_res;

    assign q_ext    = $signed({{(PROD_W-DVD_W){1'b0}}, div_quot});
    assign q_signed = neg_reg ? -q_ext : q_ext;
    assign acc_base = (phase_reg == PH_PRED) ? sel_pos : sel_snap;
    assign acc_sum  = PROD_W'(acc_base) + q_signed;
    assign acc_res  = sat_pos(acc_sum);

    // ---- sequencer ----
    logic out_load;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                    state_next = (in_cmd == CMD_TICK) ? S_MUL : S_OUT;
            end
            S_MUL:    state_next = S_DSTART;
            S_DSTART: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                if ((phase_reg == PH_PRED) && blend_on_reg)
                    state_next = S_MUL;
                else if (axis_reg == AX_X)
                    state_next = S_MUL;
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:   s_axis_tready = 1'b1;
            S_DSTART: div_start     = 1'b1;
            S_OUT:    out_load      = !m_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_PRED;
            axis_reg         <= AX_X;
            blend_win_reg    <= BLEND_RESET_MS;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            newest_time_reg  <= '0;
            newest_pos_x_reg <= '0;
            newest_pos_y_reg <= '0;
            newest_vel_x_reg <= '0;
            newest_vel_y_reg <= '0;
            snap_x_reg       <= '0;
            snap_y_reg       <= '0;
            snap_time_reg    <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_idx)
                    REG_BLEND_WINDOW: blend_win_reg <= pwdata[MS_W-1:0];
                    REG_START_X:
                    begin
                        start_x_reg <= pwdata;
                        pos_x_reg   <= pwdata;
                    end
                    REG_START_Y:
                    begin
                        start_y_reg <= pwdata;
                        pos_y_reg   <= pwdata;
                    end
                    default:
                    begin
                        blend_win_reg <= blend_win_reg;
                    end
                endcase
            end

            if (accept_in)
            begin
                phase_reg <= PH_PRED;
                axis_reg  <= AX_X;
                // stale or equal report: dropped, no snapshot
                if ((in_cmd == CMD_STORE) && report_newer)
                begin
                    newest_time_reg  <= in_rtime;
                    newest_pos_x_reg <= in_pos_x;
                    newest_pos_y_reg <= in_pos_y;
                    newest_vel_x_reg <= in_vel_x;
                    newest_vel_y_reg <= in_vel_y;
                    snap_x_reg       <= pos_x_reg;
                    snap_y_reg       <= pos_y_reg;
                    snap_time_reg    <= in_now;
                end
            end

            if (state_reg == S_ACC)
            begin
                if ((phase_reg == PH_PRED) && blend_on_reg)
                begin
                    phase_reg <= PH_BLEND;
                end
                else
                begin
                    if (axis_reg == AX_X)
                        pos_x_reg <= acc_res;
                    else
                        pos_y_reg <= acc_res;
                    axis_reg  <= AX_Y;
                    phase_reg <= PH_PRED;
                end
            end

            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            elapsed_reg    <= elapsed_clamped;
            since_reg      <= since_full[MS_W-1:0];
            blend_on_reg   <= blend_on;
            acc_flag_reg   <= (in_cmd == CMD_STORE) && report_newer;
            blend_flag_reg <= (in_cmd == CMD_TICK) && blend_on;
        end
        if (state_reg == S_MUL)
            prod_reg <= prod_full;
        if (state_reg == S_DSTART)
            neg_reg <= prod_reg[PROD_W-1];
        if (state_reg == S_ACC)
            pred_reg <= acc_res;
        if (out_load)
        begin
            m_data_reg <= {pos_y_reg, pos_x_reg};
            m_user_reg <= {blend_flag_reg, acc_flag_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== rtl/drblend_div.sv =====
`default_nettype none

// Unsigned restoring divider, DIV_BITS quotient bits per cycle.
module drblend_div
    import drblend_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     dsr_reg;

    logic [DSR_W-1:0]     rem_next;
    logic [DVD_W-1:0]     dvd_next;
    logic [DSR_W:0]       trial;
    logic                 qbit;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        trial    = '0;
        qbit     = 1'b0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_next, dvd_next[DVD_W-1]};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
                qbit  = 1'b1;
            end
            else
            begin
                qbit = 1'b0;
            end
            rem_next = trial[DSR_W-1:0];
            dvd_next = {dvd_next[DVD_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== rtl/drblend_checker.sv =====
`default_nettype none

`include "dead_reckoning_blend_macros.svh"

module drblend_checker
    import drblend_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // stalled result beat holds
    `DRB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")

    // a beat is either a store or a tick, never both flags
    `DRB_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "accepted and blending both set")

    // one beat at a time: busy right after taking a beat
    `DRB_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready straight after accepting a beat")

    // a new result only appears while the block is busy
    `DRB_ASSERT_NOW(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared without a beat in flight")

endmodule

bind dead_reckoning_blend drblend_checker u_checker (.*);

`default_nettype wire
